### hdl/pfde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared types and constants for the Playfair digraph encryption block.
// ----------------------------------------------------------------------------
package pfde_pkg;

  localparam int Side     = 5;
  localparam int CodeW    = 5;
  localparam int RowW     = Side * CodeW;
  localparam int IdxW     = $clog2(Side);
  localparam int CfgIdxW  = 3;

  typedef logic [CodeW-1:0]   code_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [RowW-1:0]    row_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam code_t CodeI    = code_t'(8);
  localparam code_t CodeJ    = code_t'(9);
  localparam code_t CodeX    = code_t'(23);
  localparam code_t CodeLast = code_t'(25);

  localparam row_t RowReset [Side] = '{
    row_t'(4294688), row_t'(10755269), row_t'(16201099),
    row_t'(21613104), row_t'(27025109)
  };

  typedef struct packed {
    code_t first_letter;
    code_t second_letter;
    logic  has_second;
  } in_item_t;

  typedef struct packed {
    code_t cipher_first;
    code_t cipher_second;
    logic  letter_missing;
  } out_item_t;

  typedef struct packed {
    idx_t row;
    idx_t col;
    logic found;
  } loc_t;

  function automatic idx_t inc_wrap(idx_t v);
    idx_t res;
    if (v == idx_t'(Side - 1)) begin
      res = '0;
    end else begin
      res = v + idx_t'(1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### hdl/pfde_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfde_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface pfde_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

### hdl/playfair_digraph_encrypt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt
// Playfair encryption of one letter pair per item against a 5x5 key square.
// ----------------------------------------------------------------------------
// The block takes one digraph per cycle while the output is not stalled and
// returns its result through four register stages (letter cleanup, square
// lookup, rule selection, cell readout with output register). A stall on the
// output freezes the whole pipeline, so items are neither lost nor repeated.
// The key square is five rows written through the configuration port; write
// them only while no item is in flight. Index values above four are ignored.
module playfair_digraph_encrypt (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire  pfde_pkg::cfg_idx_t cfg_idx_i,
  input  wire  pfde_pkg::row_t     cfg_wdata_i,
  pfde_stream_if.sink              in_i,
  pfde_stream_if.source            out_o
);

  import pfde_pkg::*;

  row_t  row_q [Side];
  code_t cell_w [Side][Side];

  logic  en_w;

  logic  s1_vld_q;
  code_t s1_a_q, s1_a_d;
  code_t s1_b_q, s1_b_d;

  logic  s2_vld_q;
  loc_t  s2_l1_q, s2_l1_d;
  loc_t  s2_l2_q, s2_l2_d;

  logic  s3_vld_q;
  logic  s3_found_q, s3_found_d;
  idx_t  s3_r1_q, s3_r1_d, s3_c1_q, s3_c1_d;
  idx_t  s3_r2_q, s3_r2_d, s3_c2_q, s3_c2_d;

  logic      s4_vld_q;
  out_item_t s4_out_q, s4_out_d;

  in_item_t in_item_w;

  assign in_item_w = in_i.item;
  assign en_w      = !s4_vld_q || out_o.ready;
  assign in_i.ready = en_w;
  assign out_o.valid = s4_vld_q;
  assign out_o.item  = s4_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Side; r++) begin
        row_q[r] <= RowReset[r];
      end
    end else if (cfg_we_i && (cfg_idx_i < cfg_idx_t'(Side))) begin
      row_q[idx_t'(cfg_idx_i)] <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        cell_w[r][c] = row_q[r][c*CodeW +: CodeW];
      end
    end
  end

  always_comb begin
    s1_a_d = in_item_w.first_letter;
    if (s1_a_d == CodeJ) begin
      s1_a_d = CodeI;
    end
    s1_b_d = in_item_w.has_second ? in_item_w.second_letter : CodeX;
    if (s1_b_d == CodeJ) begin
      s1_b_d = CodeI;
    end
    if (s1_b_d == s1_a_d) begin
      s1_b_d = CodeX;
    end
  end

  always_comb begin
    s2_l1_d = '0;
    s2_l2_d = '0;
    for (int r = Side - 1; r >= 0; r--) begin
      for (int c = Side - 1; c >= 0; c--) begin
        if ((s1_a_q <= CodeLast) && (cell_w[r][c] == s1_a_q)) begin
          s2_l1_d = '{row: idx_t'(r), col: idx_t'(c), found: 1'b1};
        end
        if ((s1_b_q <= CodeLast) && (cell_w[r][c] == s1_b_q)) begin
          s2_l2_d = '{row: idx_t'(r), col: idx_t'(c), found: 1'b1};
        end
      end
    end
  end

  always_comb begin
    s3_found_d = s2_l1_q.found && s2_l2_q.found;
    if (s2_l1_q.row == s2_l2_q.row) begin
      s3_r1_d = s2_l1_q.row;
      s3_c1_d = inc_wrap(s2_l1_q.col);
      s3_r2_d = s2_l2_q.row;
      s3_c2_d = inc_wrap(s2_l2_q.col);
    end else if (s2_l1_q.col == s2_l2_q.col) begin
      s3_r1_d = inc_wrap(s2_l1_q.row);
      s3_c1_d = s2_l1_q.col;
      s3_r2_d = inc_wrap(s2_l2_q.row);
      s3_c2_d = s2_l2_q.col;
    end else begin
      s3_r1_d = s2_l1_q.row;
      s3_c1_d = s2_l2_q.col;
      s3_r2_d = s2_l2_q.row;
      s3_c2_d = s2_l1_q.col;
    end
  end

  always_comb begin
    s4_out_d.letter_missing = !s3_found_q;
    s4_out_d.cipher_first   = s3_found_q ? cell_w[s3_r1_q][s3_c1_q] : '0;
    s4_out_d.cipher_second  = s3_found_q ? cell_w[s3_r2_q][s3_c2_q] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en_w) begin
      s1_vld_q <= in_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      s1_a_q     <= s1_a_d;
      s1_b_q     <= s1_b_d;
      s2_l1_q    <= s2_l1_d;
      s2_l2_q    <= s2_l2_d;
      s3_found_q <= s3_found_d;
      s3_r1_q    <= s3_r1_d;
      s3_c1_q    <= s3_c1_d;
      s3_r2_q    <= s3_r2_d;
      s3_c2_q    <= s3_c2_d;
      s4_out_q   <= s4_out_d;
    end
  end

  a_missing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_vld_q && s4_out_q.letter_missing) |->
      (s4_out_q.cipher_first == '0 && s4_out_q.cipher_second == '0))
    else $error("missing letter with nonzero cipher output");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_vld_q)
    else $error("accepted item did not enter stage one");

  a_loc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s2_l1_q.found) |->
      (s2_l1_q.row < idx_t'(Side) && s2_l1_q.col < idx_t'(Side)))
    else $error("located cell outside the square");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s4_vld_q |-> in_i.ready)
    else $error("input stalled with empty output stage");

endmodule
`default_nettype wire

### tb/playfair_digraph_encrypt_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt_test
// Self-checking bench for the Playfair digraph encryption block. A short
// table of letter pairs runs against the reset square first. Then a series
// of key squares is loaded: shuffled alphabets, squares with duplicate or
// out-of-range cells, raw random rows, all-zero, all-one and reset rows.
// Each square gets a burst of random pairs. Every result is compared field
// by field with its typed table entry or a behavioral Playfair encryptor
// kept in the bench. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt_test;
  import pfde_pkg::*;

  localparam int NumPhases = 13;
  localparam int DirRows   = 22;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  cfg_idx_t cfg_idx_i;
  row_t     cfg_wdata_i;

  pfde_stream_if #(.item_t(in_item_t))  plain_ch ();
  pfde_stream_if #(.item_t(out_item_t)) cipher_ch ();

  playfair_digraph_encrypt dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (plain_ch),
    .out_o      (cipher_ch)
  );

  row_t      key_rows [Side];
  out_item_t pending_ciphers [$];
  logic      typed_valid;
  out_item_t typed_cipher;
  bit        calm;
  int        idle_pct;
  int        n_errors;
  int        n_digraphs;
  int        n_missing;
  int        n_squares;

  // first  second has   typed  c_first c_second missing
  dir_row_t dir_tab [DirRows] = '{
    '{'{5'd0,  5'd1,  1'b1}, 1'b1, '{5'd1,  5'd2,  1'b0}},
    '{'{5'd0,  5'd25, 1'b1}, 1'b1, '{5'd4,  5'd21, 1'b0}},
    '{'{5'd31, 5'd0,  1'b1}, 1'b1, '{5'd0,  5'd0,  1'b1}},
    '{'{5'd0,  5'd31, 1'b1}, 1'b1, '{5'd0,  5'd0,  1'b1}},
    '{'{5'd26, 5'd26, 1'b1}, 1'b1, '{5'd0,  5'd0,  1'b1}},
    '{'{5'd25, 5'd0,  1'b0}, 1'b1, '{5'd21, 5'd24, 1'b0}},
    '{'{5'd23, 5'd0,  1'b0}, 1'b1, '{5'd24, 5'd24, 1'b0}},
    '{'{5'd31, 5'd31, 1'b0}, 1'b1, '{5'd0,  5'd0,  1'b1}},
    '{'{5'd23, 5'd23, 1'b1}, 1'b0, '0},
    '{'{5'd9,  5'd8,  1'b1}, 1'b0, '0},
    '{'{5'd8,  5'd9,  1'b1}, 1'b0, '0},
    '{'{5'd9,  5'd9,  1'b1}, 1'b0, '0},
    '{'{5'd0,  5'd5,  1'b1}, 1'b0, '0},
    '{'{5'd0,  5'd21, 1'b1}, 1'b0, '0},
    '{'{5'd3,  5'd4,  1'b1}, 1'b0, '0},
    '{'{5'd0,  5'd9,  1'b1}, 1'b0, '0},
    '{'{5'd0,  5'd31, 1'b0}, 1'b0, '0},
    '{'{5'd9,  5'd0,  1'b0}, 1'b0, '0},
    '{'{5'd24, 5'd25, 1'b1}, 1'b0, '0},
    '{'{5'd4,  5'd20, 1'b1}, 1'b0, '0},
    '{'{5'd16, 5'd10, 1'b1}, 1'b0, '0},
    '{'{5'd10, 5'd30, 1'b0}, 1'b0, '0}
  };

  function automatic code_t square_cell(int r, int c);
    return key_rows[r][CodeW*c +: CodeW];
  endfunction

  function automatic idx_t step_wrap(idx_t v);
    return (int'(v) >= Side - 1) ? idx_t'(0) : idx_t'(int'(v) + 1);
  endfunction

  function automatic loc_t find_letter(code_t letter);
    loc_t hit;
    hit = '0;
    if (letter <= CodeLast) begin
      for (int r = 0; r < Side; r++) begin
        for (int c = 0; c < Side; c++) begin
          if (!hit.found && square_cell(r, c) == letter) begin
            hit.found = 1'b1;
            hit.row   = idx_t'(r);
            hit.col   = idx_t'(c);
          end
        end
      end
    end
    return hit;
  endfunction

  function automatic out_item_t encrypt_digraph(in_item_t it);
    code_t     a;
    code_t     b;
    loc_t      la;
    loc_t      lb;
    out_item_t res;
    a = (it.first_letter == CodeJ) ? CodeI : it.first_letter;
    b = it.has_second ? it.second_letter : CodeX;
    if (b == CodeJ) b = CodeI;
    if (b == a) b = CodeX;
    la  = find_letter(a);
    lb  = find_letter(b);
    res = '0;
    res.letter_missing = !(la.found && lb.found);
    if (!res.letter_missing) begin
      if (la.row == lb.row) begin
        res.cipher_first  = square_cell(la.row, step_wrap(la.col));
        res.cipher_second = square_cell(lb.row, step_wrap(lb.col));
      end else if (la.col == lb.col) begin
        res.cipher_first  = square_cell(step_wrap(la.row), la.col);
        res.cipher_second = square_cell(step_wrap(lb.row), lb.col);
      end else begin
        res.cipher_first  = square_cell(la.row, lb.col);
        res.cipher_second = square_cell(lb.row, la.col);
      end
    end
    return res;
  endfunction

  function automatic code_t pick_letter();
    int sel;
    int r;
    int c;
    sel = $urandom_range(0, 9);
    r   = $urandom_range(0, Side - 1);
    c   = $urandom_range(0, Side - 1);
    if (sel < 7) return square_cell(r, c);
    if (sel < 9) return code_t'($urandom_range(0, 25));
    return code_t'($urandom_range(0, 31));
  endfunction

  task automatic send_digraph(input in_item_t it, input logic typed, input out_item_t want);
    if (!calm && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      plain_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    plain_ch.valid <= 1'b1;
    plain_ch.item  <= it;
    typed_valid    <= typed;
    typed_cipher   <= want;
    do @(posedge clk_i); while (plain_ch.ready !== 1'b1);
  endtask

  task automatic drain_ciphers();
    plain_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_ciphers.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : cipher_sink
    cipher_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        cipher_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      cipher_ch.ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(60, 200)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : scoreboard
    out_item_t got;
    out_item_t want;
    if (cipher_ch.valid === 1'b1 && cipher_ch.ready === 1'b1) begin
      got = cipher_ch.item;
      if (pending_ciphers.size() == 0) begin
        n_errors++;
        $error("unexpected cipher item: %0d %0d %0d",
               got.cipher_first, got.cipher_second, got.letter_missing);
      end else begin
        want = pending_ciphers.pop_front();
        if (want.letter_missing) n_missing++;
        if (got.cipher_first !== want.cipher_first) begin
          n_errors++;
          $error("cipher_first: expected %0d, got %0d",
                 want.cipher_first, got.cipher_first);
        end
        if (got.cipher_second !== want.cipher_second) begin
          n_errors++;
          $error("cipher_second: expected %0d, got %0d",
                 want.cipher_second, got.cipher_second);
        end
        if (got.letter_missing !== want.letter_missing) begin
          n_errors++;
          $error("letter_missing: expected %0d, got %0d",
                 want.letter_missing, got.letter_missing);
        end
      end
    end
    if (plain_ch.valid === 1'b1 && plain_ch.ready === 1'b1) begin
      n_digraphs++;
      pending_ciphers.push_back(typed_valid ? typed_cipher : encrypt_digraph(plain_ch.item));
    end
  end

  initial begin : stimulus
    row_t     next_rows [Side];
    code_t    perm [Side*Side];
    code_t    tmp;
    in_item_t it;
    int       kind;
    int       n_items;
    int       n_writes;
    int       m;
    int       pos;
    int       wait_cnt;

    calm         = 1'b0;
    idle_pct     = 0;
    n_errors     = 0;
    n_digraphs   = 0;
    n_missing    = 0;
    n_squares    = 1;
    for (int r = 0; r < Side; r++) key_rows[r] = RowReset[r];
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_wdata_i    <= '0;
    plain_ch.valid <= 1'b0;
    plain_ch.item  <= '0;
    typed_valid    <= 1'b0;
    typed_cipher   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    idle_pct = 20;
    for (int k = 0; k < DirRows; k++) begin
      send_digraph(dir_tab[k].stim, dir_tab[k].typed, dir_tab[k].want);
    end
    drain_ciphers();

    for (int p = 0; p < NumPhases; p++) begin
      calm = (p >= NumPhases - 2);
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 5;
        2: idle_pct = 20;
        default: idle_pct = 45;
      endcase

      case (p)
        0: kind = 9;
        1: kind = 10;
        2: kind = 11;
        3: kind = 6;
        4: kind = 8;
        default: kind = $urandom_range(0, 9);
      endcase

      pos = 0;
      for (int code = 0; code <= 25; code++) begin
        if (code_t'(code) != CodeJ) begin
          perm[pos] = code_t'(code);
          pos++;
        end
      end
      for (int k = Side*Side - 1; k > 0; k--) begin
        m       = $urandom_range(0, k);
        tmp     = perm[k];
        perm[k] = perm[m];
        perm[m] = tmp;
      end
      if (kind == 6 || kind == 7) begin
        repeat ($urandom_range(1, 4)) begin
          perm[$urandom_range(0, Side*Side - 1)] = code_t'($urandom_range(0, 31));
        end
      end
      for (int r = 0; r < Side; r++) begin
        for (int c = 0; c < Side; c++) next_rows[r][CodeW*c +: CodeW] = perm[r*Side + c];
        case (kind)
          8: next_rows[r] = row_t'($urandom);
          9: next_rows[r] = RowReset[r];
          10: next_rows[r] = '1;
          11: next_rows[r] = '0;
          default: ;
        endcase
      end

      n_writes = Side + $urandom_range(0, 1);
      for (int k = 0; k < n_writes; k++) begin
        cfg_we_i    <= 1'b1;
        cfg_idx_i   <= (k < Side) ? cfg_idx_t'(k) : cfg_idx_t'($urandom_range(Side, 7));
        cfg_wdata_i <= (k < Side) ? next_rows[k] : row_t'($urandom);
        @(posedge clk_i);
        if (k < Side) key_rows[k] = next_rows[k];
      end
      cfg_we_i <= 1'b0;
      n_squares++;

      n_items = (p == 1 || p == 2) ? 60 : 155;
      for (int k = 0; k < n_items; k++) begin
        if (p == 5 && k == n_items / 2) begin
          plain_ch.valid <= 1'b0;
          @(posedge clk_i);
          while (pending_ciphers.size() != 0) @(posedge clk_i);
        end
        it.first_letter  = pick_letter();
        it.second_letter = pick_letter();
        if ($urandom_range(0, 9) == 0) it.second_letter = it.first_letter;
        it.has_second    = ($urandom_range(0, 6) != 0);
        send_digraph(it, 1'b0, '0);
      end
      drain_ciphers();
    end

    wait_cnt = 0;
    while (pending_ciphers.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_ciphers.size() != 0) begin
      n_errors++;
      $error("%0d cipher items never arrived", pending_ciphers.size());
    end

    $display("Encrypted %0d digraphs under %0d key squares", n_digraphs, n_squares);
    $display("(reset, all-zero, all-one, shuffled, corrupted, raw); %0d had missing letters",
             n_missing);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hdl/pfde_pkg.sv
hdl/pfde_stream_if.sv
hdl/playfair_digraph_encrypt.sv
tb/playfair_digraph_encrypt_test.sv
